// ===== src/sha1_pkg.sv =====
package sha1_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned NUM_H   = 5;
	localparam int unsigned NUM_W   = 16;
	localparam int unsigned ROUNDS  = 80;
	localparam int unsigned BLK_LEN = 64;
	localparam int unsigned LEN_POS = 56;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t INIT_VEC [NUM_H] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t ROUND_K [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} dig_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	function automatic word_t rotl(input word_t v, input int unsigned s);
		rotl = (v << s) | (v >> (WORD_W - s));
	endfunction

endpackage

// ===== src/sha1_hash_engine.sv =====
// SHA-1 hash engine.
// Input channel msg (msg_valid/msg_ready): one item per transfer. kind append
// shifts data_byte into the 64-byte block register; kind finish pads the
// message (0x80, zeros, 64-bit big-endian bit length) and emits the digest.
// Output channel dig (dig_valid/dig_ready): five transfers per finish, word 0
// (most significant) first, last_word set on word 4.
// Steps:
//   append      shifts one byte into the block; the 64th byte of a block also
//               starts a compression of 80 rounds followed by a fold step.
//   finish      shifts pad bytes up to the block end, compresses the block
//               (two blocks when 56 or more bytes are pending), then offers
//               5 digest words at one per cycle while dig_ready is high.
// One SHA-1 round per clock; the message schedule is a 16-word shift register.
// msg_ready is high only while idle; the block takes no byte while padding,
// compressing or emitting.
// Reset (arst_n low, async) restores the initial vector and clears the bit
// length and byte count. If the receiver stalls dig_ready, the current word
// holds on dig and the engine waits; no word is lost. After the last digest
// transfer the chaining words are back at the initial vector.
module sha1_hash_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 msg_valid,
	output logic                 msg_ready,
	input  sha1_pkg::msg_item_t  msg,
	output logic                 dig_valid,
	input  logic                 dig_ready,
	output sha1_pkg::dig_item_t  dig
);

	// sequencer
	sha1_pkg::state_t state_q, state_d;

	// chaining words, bit length, byte count, finish bookkeeping
	sha1_pkg::word_t h_q [sha1_pkg::NUM_H];
	logic [63:0]     bit_len_q;
	logic [5:0]      cnt_q;          // pending bytes 0..63
	logic            fin_q;          // finish in progress
	logic            extra_q;        // length goes in the next block
	logic            mark_q;         // 0x80 already written
	logic [6:0]      rnd_q;          // round 0..79
	logic [2:0]      idx_q;          // digest word being offered

	// block / schedule shift register and working variables
	sha1_pkg::word_t blk_q [sha1_pkg::NUM_W];
	sha1_pkg::word_t v_q [sha1_pkg::NUM_H];

	logic msg_xfer, dig_xfer;
	logic shift_en;                  // shift one byte into the block
	logic blk_start;                 // load working vars from chain
	logic [7:0] shift_byte;
	logic [7:0] len_byte;
	logic       blk_full;

	assign msg_xfer = msg_valid && msg_ready;
	assign dig_xfer = dig_valid && dig_ready;
	assign blk_full = (cnt_q == 6'(sha1_pkg::BLK_LEN - 1));

	// length byte k sits at block position 56 + k, most significant first
	assign len_byte = 8'(bit_len_q >> {~cnt_q[2:0], 3'b000});

	always_comb begin
		if (state_q == sha1_pkg::ST_IDLE) begin
			shift_byte = msg.data_byte;
		end else if (!mark_q) begin
			shift_byte = sha1_pkg::PAD_MARK;
		end else if (cnt_q >= 6'(sha1_pkg::LEN_POS) && !extra_q) begin
			shift_byte = len_byte;
		end else begin
			shift_byte = 8'h00;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (msg_xfer) begin
					if (msg.kind == sha1_pkg::KIND_FINISH) begin
						state_d = sha1_pkg::ST_PAD;
					end else if (blk_full) begin
						state_d = sha1_pkg::ST_ROUND;
					end
				end
			end
			sha1_pkg::ST_PAD: begin
				if (blk_full) begin
					state_d = sha1_pkg::ST_ROUND;
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (rnd_q == 7'(sha1_pkg::ROUNDS - 1)) begin
					state_d = sha1_pkg::ST_FOLD;
				end
			end
			sha1_pkg::ST_FOLD: begin
				if (!fin_q) begin
					state_d = sha1_pkg::ST_IDLE;
				end else if (extra_q) begin
					state_d = sha1_pkg::ST_PAD;
				end else begin
					state_d = sha1_pkg::ST_EMIT;
				end
			end
			sha1_pkg::ST_EMIT: begin
				if (dig_ready && idx_q == 3'(sha1_pkg::NUM_H - 1)) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: state_d = sha1_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		shift_en  = 1'b0;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				msg_ready = 1'b1;
				shift_en  = msg_valid && (msg.kind == sha1_pkg::KIND_APPEND);
			end
			sha1_pkg::ST_PAD:  shift_en  = 1'b1;
			sha1_pkg::ST_EMIT: dig_valid = 1'b1;
			default: begin
				msg_ready = 1'b0;
			end
		endcase
		blk_start = (state_d == sha1_pkg::ST_ROUND) && (state_q != sha1_pkg::ST_ROUND);
	end

	assign dig.digest_word = h_q[0];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == 3'(sha1_pkg::NUM_H - 1));

	// round datapath
	sha1_pkg::word_t w_cur, f_val, k_val, t_val;

	always_comb begin
		if (rnd_q < 7'd16) begin
			w_cur = blk_q[0];
		end else begin
			w_cur = sha1_pkg::rotl(blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0], 1);
		end
		if (rnd_q < 7'd20) begin
			f_val = (v_q[1] & v_q[2]) | (~v_q[1] & v_q[3]);
			k_val = sha1_pkg::ROUND_K[0];
		end else if (rnd_q < 7'd40) begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_val = sha1_pkg::ROUND_K[1];
		end else if (rnd_q < 7'd60) begin
			f_val = (v_q[1] & v_q[2]) | (v_q[1] & v_q[3]) | (v_q[2] & v_q[3]);
			k_val = sha1_pkg::ROUND_K[2];
		end else begin
			f_val = v_q[1] ^ v_q[2] ^ v_q[3];
			k_val = sha1_pkg::ROUND_K[3];
		end
		t_val = sha1_pkg::rotl(v_q[0], 5) + f_val + v_q[4] + w_cur + k_val;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sha1_pkg::ST_IDLE;
			bit_len_q <= '0;
			cnt_q     <= '0;
			fin_q     <= 1'b0;
			extra_q   <= 1'b0;
			mark_q    <= 1'b0;
			rnd_q     <= '0;
			idx_q     <= '0;
			for (int i = 0; i < sha1_pkg::NUM_H; i++) begin
				h_q[i] <= sha1_pkg::INIT_VEC[i];
			end
		end else begin
			state_q <= state_d;
			if (shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (state_q == sha1_pkg::ST_IDLE && shift_en) begin
				bit_len_q <= bit_len_q + 64'd8;
			end
			if (msg_xfer && msg.kind == sha1_pkg::KIND_FINISH) begin
				fin_q   <= 1'b1;
				extra_q <= (cnt_q >= 6'(sha1_pkg::LEN_POS));
			end
			if (state_q == sha1_pkg::ST_PAD) begin
				mark_q <= 1'b1;
			end
			if (state_q == sha1_pkg::ST_ROUND) begin
				if (rnd_q == 7'(sha1_pkg::ROUNDS - 1)) begin
					rnd_q <= '0;
				end else begin
					rnd_q <= rnd_q + 7'd1;
				end
			end
			if (state_q == sha1_pkg::ST_FOLD) begin
				extra_q <= 1'b0;
				for (int i = 0; i < sha1_pkg::NUM_H; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (dig_xfer) begin
				if (dig.last_word) begin
					idx_q     <= '0;
					fin_q     <= 1'b0;
					mark_q    <= 1'b0;
					bit_len_q <= '0;
					for (int i = 0; i < sha1_pkg::NUM_H; i++) begin
						h_q[i] <= sha1_pkg::INIT_VEC[i];
					end
				end else begin
					idx_q <= idx_q + 3'd1;
					for (int i = 0; i < sha1_pkg::NUM_H - 1; i++) begin
						h_q[i] <= h_q[i+1];
					end
				end
			end
		end
	end

	// payload registers: block shift line and working variables
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < sha1_pkg::NUM_W - 1; i++) begin
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			end
			blk_q[sha1_pkg::NUM_W-1] <= {blk_q[sha1_pkg::NUM_W-1][23:0], shift_byte};
		end else if (state_q == sha1_pkg::ST_ROUND) begin
			for (int i = 0; i < sha1_pkg::NUM_W - 1; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[sha1_pkg::NUM_W-1] <= w_cur;
		end
		if (blk_start) begin
			for (int i = 0; i < sha1_pkg::NUM_H; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == sha1_pkg::ST_ROUND) begin
			v_q[0] <= t_val;
			v_q[1] <= v_q[0];
			v_q[2] <= sha1_pkg::rotl(v_q[1], 30);
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3];
		end
	end

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("input taken while digest pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_ready && dig.last_word) |=> msg_ready)
		else $error("engine not idle after last digest word");

	a_emit_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (cnt_q == 6'd0 && !extra_q))
		else $error("digest emitted with bytes pending");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q < 7'(sha1_pkg::ROUNDS))
		else $error("round counter out of range");

	a_fold_after_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha1_pkg::ST_ROUND && rnd_q == 7'(sha1_pkg::ROUNDS - 1))
		|=> (state_q == sha1_pkg::ST_FOLD && rnd_q == 7'd0))
		else $error("fold step missed after final round");

endmodule
